[rtl/twm_pkg.sv]
package twm_pkg;

    // default geometry
    localparam int MEM_WORDS_DEF   = 100;
    localparam int BLOCK_WORDS_DEF = 10;

    // field widths
    localparam int OP_W     = 3;
    localparam int ADDR_W   = 7;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 4;
    localparam int IC_W     = 7;
    localparam int CNT_W    = 4;
    localparam int MODE_W   = 2;

    // input operations
    localparam logic [OP_W-1:0] OP_NEW   = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 3'd1;
    localparam logic [OP_W-1:0] OP_START = 3'd2;
    localparam logic [OP_W-1:0] OP_STEP  = 3'd3;
    localparam logic [OP_W-1:0] OP_CARD  = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_EXEC    = 4'd0;
    localparam logic [STATUS_W-1:0] ST_PRINT   = 4'd1;
    localparam logic [STATUS_W-1:0] ST_HALT    = 4'd2;
    localparam logic [STATUS_W-1:0] ST_AWAIT   = 4'd3;
    localparam logic [STATUS_W-1:0] ST_CARD    = 4'd4;
    localparam logic [STATUS_W-1:0] ST_LOADED  = 4'd5;
    localparam logic [STATUS_W-1:0] ST_BAD     = 4'd6;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 4'd7;
    localparam logic [STATUS_W-1:0] ST_STARTED = 4'd8;

    // machine modes
    localparam logic [MODE_W-1:0] MODE_IDLE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RUN   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CARDS = 2'd2;

    // characters
    localparam logic [7:0] CH_ZERO = 8'd48;
    localparam logic [7:0] CH_NINE = 8'd57;
    localparam logic [7:0] CH_G    = 8'h47;
    localparam logic [7:0] CH_D    = 8'h44;
    localparam logic [7:0] CH_P    = 8'h50;
    localparam logic [7:0] CH_H    = 8'h48;
    localparam logic [7:0] CH_L    = 8'h4C;
    localparam logic [7:0] CH_R    = 8'h52;
    localparam logic [7:0] CH_S    = 8'h53;
    localparam logic [7:0] CH_C    = 8'h43;
    localparam logic [7:0] CH_B    = 8'h42;
    localparam logic [7:0] CH_T    = 8'h54;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] address;
        logic [WORD_W-1:0] word;
    } cmd_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WORD_W-1:0]   out_word;
        logic                last;
        logic [IC_W-1:0]     instr_counter;
        logic                compare_flag;
    } res_item_t;

endpackage

[rtl/twm_ram.sv]
module twm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 100
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/toy_word_machine_executor.sv]
// path from accept to res_valid: load, card, start, new job and ignored beats go straight to
// the emit state; a step passes through the fetch read, LR and CR also through the operand read
// PD, after the fetch, reads, captures and emits each word of its block in turn, and every
// emit waits while res_stall holds the previous result in the output register
// one command at a time: the next command is taken once the last result is in the output register
// reset: async active-low; clears R, C, IC, mode, card counters and all memory valid bits,
//   so memory reads as zero; new job clears all the valid bits together, no clearing pass
module toy_word_machine_executor
    import twm_pkg::*;
#(
    parameter int MEM_WORDS   = MEM_WORDS_DEF,
    parameter int BLOCK_WORDS = BLOCK_WORDS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_item_t cmd,
    output logic      res_valid,
    input  logic      res_stall,
    output res_item_t res
);

    localparam int AW = $clog2(MEM_WORDS);

    // sequencer states
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_FETCH   = 3'd1;
    localparam logic [2:0] S_OPND    = 3'd2;
    localparam logic [2:0] S_PD_RD   = 3'd3;
    localparam logic [2:0] S_PD_DATA = 3'd4;
    localparam logic [2:0] S_EMIT    = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic [MODE_W-1:0]    mode_reg, mode_next;
    logic [IC_W-1:0]      ic_reg, ic_next;
    logic                 c_reg, c_next;
    logic [WORD_W-1:0]    r_reg, r_next;
    logic [IC_W-1:0]      card_base_reg, card_base_next;
    logic [CNT_W-1:0]     card_count_reg, card_count_next;
    logic [MEM_WORDS-1:0] valid_reg, valid_next;
    logic                 rd_valid_reg;

    // pending result, held until the output register is free
    logic [STATUS_W-1:0]  pend_status_reg, pend_status_next;
    logic [WORD_W-1:0]    pend_word_reg, pend_word_next;
    logic                 pend_last_reg, pend_last_next;

    // print block walk
    logic [IC_W-1:0]      pd_base_reg, pd_base_next;
    logic [CNT_W-1:0]     pd_idx_reg, pd_idx_next;
    logic                 opnd_cr_reg, opnd_cr_next;

    logic                 res_valid_reg, res_valid_next;
    res_item_t            res_reg, res_next;

    // memory port
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_W-1:0]    ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [WORD_W-1:0]    ram_rdata;
    logic [WORD_W-1:0]    rd_word;

    // instruction decode of the fetched word
    logic [7:0]           c0, c1, c2, c3;
    logic [3:0]           d2, d3;
    logic [IC_W-1:0]      tens, opnd_n;
    logic                 digits_ok, uses_operand, block_bad;
    logic [IC_W:0]        card_slot;
    logic [IC_W-1:0]      pd_addr;
    logic [CNT_W-1:0]     card_count_inc;

    twm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MEM_WORDS)
    ) u_mem (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // an entry not written since the last new job reads as zero
    assign rd_word = rd_valid_reg ? ram_rdata : '0;

    assign c0 = rd_word[31:24];
    assign c1 = rd_word[23:16];
    assign c2 = rd_word[15:8];
    assign c3 = rd_word[7:0];
    assign d2 = 4'(c2 - CH_ZERO);
    assign d3 = 4'(c3 - CH_ZERO);

    assign digits_ok = (c2 >= CH_ZERO) && (c2 <= CH_NINE) &&
                       (c3 >= CH_ZERO) && (c3 <= CH_NINE);
    // tens digit times ten as two shifts
    assign tens      = {d2, 3'b000} + {2'b00, d2, 1'b0};
    assign opnd_n    = tens + {3'b000, d3};
    assign block_bad = ({1'b0, tens} + (IC_W+1)'(BLOCK_WORDS)) > (IC_W+1)'(MEM_WORDS);

    assign uses_operand = ((c0 == CH_L) && (c1 == CH_R)) || ((c0 == CH_S) && (c1 == CH_R)) ||
                          ((c0 == CH_C) && (c1 == CH_R)) || ((c0 == CH_B) && (c1 == CH_T)) ||
                          ((c0 == CH_G) && (c1 == CH_D)) || ((c0 == CH_P) && (c1 == CH_D));

    assign card_slot      = {1'b0, card_base_reg} + {{(IC_W+1-CNT_W){1'b0}}, card_count_reg};
    assign card_count_inc = card_count_reg + 1'b1;
    assign pd_addr        = pd_base_reg + {{(IC_W-CNT_W){1'b0}}, pd_idx_reg};

    always_comb
    begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        ic_next          = ic_reg;
        c_next           = c_reg;
        r_next           = r_reg;
        card_base_next   = card_base_reg;
        card_count_next  = card_count_reg;
        valid_next       = valid_reg;
        pend_status_next = pend_status_reg;
        pend_word_next   = pend_word_reg;
        pend_last_next   = pend_last_reg;
        pd_base_next     = pd_base_reg;
        pd_idx_next      = pd_idx_reg;
        opnd_cr_next     = opnd_cr_reg;
        res_next         = res_reg;
        res_valid_next   = res_valid_reg && res_stall;
        ram_we           = 1'b0;
        ram_waddr        = '0;
        ram_wdata        = '0;
        ram_re           = 1'b0;
        ram_raddr        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    pend_word_next = '0;
                    pend_last_next = 1'b1;
                    state_next     = S_EMIT;
                    case (cmd.op)
                        OP_NEW:
                        begin
                            valid_next       = '0;
                            r_next           = '0;
                            c_next           = 1'b0;
                            mode_next        = MODE_IDLE;
                            card_count_next  = '0;
                            pend_status_next = ST_EXEC;
                        end
                        OP_LOAD:
                        begin
                            if (cmd.address < ADDR_W'(MEM_WORDS))
                            begin
                                ram_we                      = 1'b1;
                                ram_waddr                   = cmd.address[AW-1:0];
                                ram_wdata                   = cmd.word;
                                valid_next[cmd.address[AW-1:0]] = 1'b1;
                                pend_status_next            = ST_LOADED;
                            end
                            else
                            begin
                                pend_status_next = ST_BAD;
                            end
                        end
                        OP_START:
                        begin
                            ic_next          = '0;
                            card_count_next  = '0;
                            mode_next        = MODE_RUN;
                            pend_status_next = ST_STARTED;
                        end
                        OP_STEP:
                        begin
                            if (mode_reg != MODE_RUN)
                            begin
                                pend_status_next = ST_IGNORED;
                            end
                            else if (ic_reg >= IC_W'(MEM_WORDS))
                            begin
                                mode_next        = MODE_IDLE;
                                pend_status_next = ST_BAD;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = ic_reg[AW-1:0];
                                state_next = S_FETCH;
                            end
                        end
                        OP_CARD:
                        begin
                            if ((mode_reg != MODE_CARDS) ||
                                (card_slot >= (IC_W+1)'(MEM_WORDS)) ||
                                (card_count_reg >= CNT_W'(BLOCK_WORDS)))
                            begin
                                pend_status_next = ST_IGNORED;
                            end
                            else
                            begin
                                ram_we                        = 1'b1;
                                ram_waddr                     = card_slot[AW-1:0];
                                ram_wdata                     = cmd.word;
                                valid_next[card_slot[AW-1:0]] = 1'b1;
                                pend_status_next              = ST_CARD;
                                if (card_count_inc >= CNT_W'(BLOCK_WORDS))
                                begin
                                    card_count_next = '0;
                                    mode_next       = MODE_RUN;
                                end
                                else
                                begin
                                    card_count_next = card_count_inc;
                                end
                            end
                        end
                        default:
                        begin
                            pend_status_next = ST_IGNORED;
                        end
                    endcase
                end
            end

            S_FETCH:
            begin
                ic_next          = ic_reg + 1'b1;
                state_next       = S_EMIT;
                pend_status_next = ST_EXEC;
                if (c0 == CH_H)
                begin
                    mode_next        = MODE_IDLE;
                    pend_status_next = ST_HALT;
                end
                else if (!uses_operand)
                begin
                    pend_status_next = ST_EXEC;
                end
                else if (!digits_ok)
                begin
                    mode_next        = MODE_IDLE;
                    pend_status_next = ST_BAD;
                end
                else if ((c0 == CH_G) || (c0 == CH_P))
                begin
                    if (block_bad)
                    begin
                        mode_next        = MODE_IDLE;
                        pend_status_next = ST_BAD;
                    end
                    else if (c0 == CH_G)
                    begin
                        mode_next        = MODE_CARDS;
                        card_base_next   = tens;
                        card_count_next  = '0;
                        pend_status_next = ST_AWAIT;
                    end
                    else
                    begin
                        pd_base_next = tens;
                        pd_idx_next  = '0;
                        state_next   = S_PD_RD;
                    end
                end
                else if (opnd_n >= IC_W'(MEM_WORDS))
                begin
                    mode_next        = MODE_IDLE;
                    pend_status_next = ST_BAD;
                end
                else if ((c0 == CH_L) || (c0 == CH_C))
                begin
                    ram_re       = 1'b1;
                    ram_raddr    = opnd_n[AW-1:0];
                    opnd_cr_next = (c0 == CH_C);
                    state_next   = S_OPND;
                end
                else if (c0 == CH_S)
                begin
                    ram_we                     = 1'b1;
                    ram_waddr                  = opnd_n[AW-1:0];
                    ram_wdata                  = r_reg;
                    valid_next[opnd_n[AW-1:0]] = 1'b1;
                end
                else if (c_reg)
                begin
                    // branch on true overrides the advance
                    ic_next = opnd_n;
                end
            end

            S_OPND:
            begin
                if (opnd_cr_reg)
                begin
                    c_next = (rd_word == r_reg);
                end
                else
                begin
                    r_next = rd_word;
                end
                pend_status_next = ST_EXEC;
                state_next       = S_EMIT;
            end

            S_PD_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = pd_addr[AW-1:0];
                state_next = S_PD_DATA;
            end

            S_PD_DATA:
            begin
                pend_status_next = ST_PRINT;
                pend_word_next   = rd_word;
                pend_last_next   = (pd_idx_reg == CNT_W'(BLOCK_WORDS - 1));
                state_next       = S_EMIT;
            end

            S_EMIT:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_next.status        = pend_status_reg;
                    res_next.out_word      = pend_word_reg;
                    res_next.last          = pend_last_reg;
                    res_next.instr_counter = ic_reg;
                    res_next.compare_flag  = c_reg;
                    res_valid_next         = 1'b1;
                    if ((pend_status_reg == ST_PRINT) && !pend_last_reg)
                    begin
                        pd_idx_next = pd_idx_reg + 1'b1;
                        state_next  = S_PD_RD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_reg       <= MODE_IDLE;
            ic_reg         <= '0;
            c_reg          <= 1'b0;
            r_reg          <= '0;
            card_base_reg  <= '0;
            card_count_reg <= '0;
            valid_reg      <= '0;
            rd_valid_reg   <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            ic_reg         <= ic_next;
            c_reg          <= c_next;
            r_reg          <= r_next;
            card_base_reg  <= card_base_next;
            card_count_reg <= card_count_next;
            valid_reg      <= valid_next;
            res_valid_reg  <= res_valid_next;
            if (ram_re)
            begin
                rd_valid_reg <= valid_reg[ram_raddr];
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pend_status_reg <= pend_status_next;
        pend_word_reg   <= pend_word_next;
        pend_last_reg   <= pend_last_next;
        pd_base_reg     <= pd_base_next;
        pd_idx_reg      <= pd_idx_next;
        opnd_cr_reg     <= opnd_cr_next;
        res_reg         <= res_next;
    end

    assign cmd_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // memory port is never read and written in the same cycle
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("memory read and write in the same cycle");

    // operand read always follows an instruction fetch
    a_opnd_after_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OPND) |-> ($past(state_reg) == S_FETCH))
        else $error("operand read without fetch");

    // card counter stays inside the block
    a_card_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        card_count_reg < CNT_W'(BLOCK_WORDS))
        else $error("card count out of range");

    // counter never passes one beyond the last word
    a_ic_range: assert property (@(posedge clk) disable iff (!rst_n)
        ic_reg <= IC_W'(MEM_WORDS))
        else $error("instruction counter out of range");

    // a print beat only appears after a captured memory word
    a_print_source: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && pend_status_reg == ST_PRINT) |->
            ($past(state_reg) == S_PD_DATA || $past(state_reg) == S_EMIT))
        else $error("print beat without memory read");

endmodule
